[rtl/crc14_packet_framer_assert.svh]
// Assertion macros for the framer RTL.
`ifndef CRC14_PACKET_FRAMER_ASSERT_SVH
`define CRC14_PACKET_FRAMER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CPF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CPF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/crc14pf_pkg.sv]
`timescale 1ns / 1ps
package crc14pf_pkg;

   localparam logic [13:0] CRC_INIT = 14'h3fff;
   localparam logic [13:0] CRC_POLY = 14'h22f0;
   localparam int unsigned CRC_BITS_PER_BYTE = 7;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   typedef enum logic {
      JOB_HEADER = 1'b0,
      JOB_DATA   = 1'b1
   } job_op_type;

   // bytes[0] is sent first; a data job uses bytes[0] only
   typedef struct packed {
      job_op_type       op;
      logic             crc_after;
      logic [2:0][7:0]  bytes;
   } job_type;

   function automatic logic [13:0] crc14_take(input logic [13:0] crc, input logic [7:0] b);
      logic [13:0] c;
      c = crc ^ {7'd0, b[6:0]};
      for (int k = 0; k < CRC_BITS_PER_BYTE; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[rtl/crc14pf_front.sv]
`timescale 1ns / 1ps
module crc14pf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,
   input  logic                  req_tuser,
   input  logic                  q_full,
   output logic                  push,
   output crc14pf_pkg::job_type  push_job
);
   import crc14pf_pkg::*;

   logic       open_ff, open_in;
   logic [7:0] left_ff, left_in;
   logic       accept;
   logic [7:0] dest_address, command_code, packet_length, data_byte;

   assign dest_address  = req_tdata[7:0];
   assign command_code  = req_tdata[15:8];
   assign packet_length = req_tdata[23:16];
   assign data_byte     = req_tdata[31:24];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   always_comb begin
      open_in  = open_ff;
      left_in  = left_ff;
      push     = 1'b0;
      push_job = '0;
      if (accept) begin
         if (req_tuser == KIND_START) begin
            // a new start drops whatever packet was open
            push_job.op        = JOB_HEADER;
            push_job.bytes[0]  = dest_address;
            push_job.bytes[1]  = command_code;
            push_job.bytes[2]  = packet_length;
            push_job.crc_after = (packet_length == 8'd0);
            push               = 1'b1;
            open_in            = (packet_length != 8'd0);
            left_in            = packet_length;
         end else if (open_ff && (left_ff != 8'd0)) begin
            push_job.op        = JOB_DATA;
            push_job.bytes[0]  = data_byte;
            push_job.crc_after = (left_ff == 8'd1);
            push               = 1'b1;
            open_in            = (left_ff != 8'd1);
            left_in            = left_ff - 8'd1;
         end
         // stray data word outside a packet: swallowed
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         left_ff <= 8'd0;
      end else begin
         open_ff <= open_in;
         left_ff <= left_in;
      end
   end

endmodule

[rtl/crc14pf_queue.sv]
`timescale 1ns / 1ps
module crc14pf_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  crc14pf_pkg::job_type  push_job,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output crc14pf_pkg::job_type  head_job
);
   import crc14pf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/crc14pf_back.sv]
`timescale 1ns / 1ps
module crc14pf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  crc14pf_pkg::job_type  head_job,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast
);
   import crc14pf_pkg::*;

   logic [2:0]  step_ff, step_in;
   logic [13:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        advance;
   logic [2:0]  n_data;
   logic        is_data, is_crc_lo, is_crc_hi, last_step;
   logic [1:0]  sel_idx;
   logic [7:0]  data_sel, byte_out;
   logic [13:0] crc_v, crc_base;

   assign advance   = head_valid && (!rsp_valid_ff || rsp_tready);
   assign n_data    = (head_job.op == JOB_HEADER) ? 3'd3 : 3'd1;
   assign is_data   = (step_ff < n_data);
   assign is_crc_lo = (step_ff == n_data);
   assign is_crc_hi = (step_ff == n_data + 3'd1);
   assign last_step = head_job.crc_after ? is_crc_hi : (step_ff == n_data - 3'd1);
   assign sel_idx   = is_data ? step_ff[1:0] : 2'd0;
   assign data_sel  = head_job.bytes[sel_idx];
   assign crc_v     = crc_ff ^ CRC_INIT;
   // header restarts the checksum on its first byte
   assign crc_base  = ((head_job.op == JOB_HEADER) && (step_ff == 3'd0)) ? CRC_INIT : crc_ff;

   always_comb begin
      if (is_data) begin
         byte_out = data_sel;
      end else if (is_crc_lo) begin
         byte_out = {1'b0, crc_v[6:0]};
      end else begin
         byte_out = {1'b0, crc_v[13:7]};
      end
   end

   always_comb begin
      step_in      = step_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = byte_out;
         rsp_last_in  = is_crc_hi;
         if (is_data) begin
            crc_in = crc14_take(crc_base, data_sel);
         end else if (is_crc_hi) begin
            crc_in = CRC_INIT;
         end
         step_in = last_step ? 3'd0 : step_ff + 3'd1;
         pop     = last_step;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 3'd0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`include "crc14_packet_framer_assert.svh"

   `CPF_ASSERT_NOW(a_step_idle, !head_valid, step_ff == 3'd0, "step count left over with no job")
   `CPF_ASSERT_NOW(a_last_is_crc, rsp_valid_ff && rsp_last_ff, rsp_data_ff[7] == 1'b0, "closing byte wider than 7 bits")
   `CPF_ASSERT_NEXT(a_crc_rearm, advance && is_crc_hi, crc_ff == CRC_INIT, "checksum not rearmed after packet")

endmodule

[rtl/crc14_packet_framer.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake            tdata                          tuser / tlast
// req      in   req_tvalid/tready    dest,cmd,len,data (low->high)  tuser: kind
// rsp      out  rsp_tvalid/tready    out_byte                       tlast: end_of_packet
//
// Input words are taken one per cycle while the job queue (QUEUE_DEPTH deep) has room.
// Output runs one byte per cycle unless rsp_tready holds it: a start word yields 3 bytes
// (5 with an empty packet), a data word 1 byte (3 when it closes the packet); the single
// byte lane sets the rate. A data word outside a packet is taken and produces nothing.
// Reset is synchronous and clears queue, packet tracking and output valid; no sweep.
// Either side may stall; the queue lets the input run on while output is held.
module crc14_packet_framer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // dest_address, command_code, packet_length, data_byte
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast
);
   import crc14pf_pkg::*;

   logic    q_full, push, pop, head_valid;
   job_type push_job, head_job;

   crc14pf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_job   (push_job)
   );

   crc14pf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   crc14pf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
